// ----- rtl/tts_pkg.sv -----
// Shared types and character constants of the terminal text sanitizer.
package tts_pkg;

   localparam logic [7:0] BYTE_BEL   = 8'h07;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_LF    = 8'h0a;
   localparam logic [7:0] BYTE_CR    = 8'h0d;
   localparam logic [7:0] BYTE_ESC   = 8'h1b;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_FINAL_LO = 8'h40;
   localparam logic [7:0] BYTE_LBRACK = 8'h5b;
   localparam logic [7:0] BYTE_BSLASH = 8'h5c;
   localparam logic [7:0] BYTE_RBRACK = 8'h5d;
   localparam logic [7:0] BYTE_TILDE = 8'h7e;
   localparam logic [7:0] BYTE_HIGH  = 8'h80;
   localparam logic [7:0] CONT_MASK  = 8'hc0;

   localparam logic [6:0] CHAR_LF    = 7'h0a;
   localparam logic [6:0] CHAR_SPACE = 7'h20;
   localparam logic [6:0] CHAR_QMARK = 7'h3f;

   localparam logic [2:0] MAX_RESULTS = 3'd5;

   // What one request emits: an optional leading LF, then body_cnt copies of body_char.
   typedef struct packed {
      logic       pre_lf;
      logic [6:0] body_char;
      logic [2:0] body_cnt;
      logic       text_last;
   } plan_type;

endpackage

// ----- rtl/tts_parser.sv -----
// Escape-sequence parser and tab counter; turns one request byte into an output plan.
module tts_parser #(
   parameter int TAB_STOP = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output tts_pkg::plan_type plan
);
   import tts_pkg::*;

   localparam int CW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
   localparam logic [CW-1:0] CNT_TOP = CW'(TAB_STOP - 1);
   localparam logic [4:0] STOP5 = 5'(TAB_STOP);

   typedef enum logic [2:0] {
      MODE_NORMAL  = 3'd0,
      MODE_START   = 3'd1,
      MODE_CSI     = 3'd2,
      MODE_OSC     = 3'd3,
      MODE_OSC_ESC = 3'd4,
      MODE_CR_PEND = 3'd5,
      MODE_SKIP    = 3'd6
   } mode_type;

   mode_type      mode_ff, mode_in;
   logic [CW-1:0] count_ff, count_in;

   logic          plain;
   logic [CW-1:0] cnt1;
   logic [4:0]    sp;
   logic [2:0]    cap;
   logic [2:0]    emit;
   logic [4:0]    sum;

   always_comb begin
      plain   = 1'b0;
      mode_in = MODE_NORMAL;
      plan.pre_lf    = 1'b0;
      plan.body_char = 7'd0;
      plan.body_cnt  = 3'd0;
      plan.text_last = in_last;

      case (mode_ff)
         MODE_START: begin
            if (in_byte == BYTE_LBRACK) mode_in = MODE_CSI;
            else if (in_byte == BYTE_RBRACK) mode_in = MODE_OSC;
         end
         MODE_CSI: begin
            if (!(in_byte >= BYTE_FINAL_LO && in_byte <= BYTE_TILDE)) mode_in = MODE_CSI;
         end
         MODE_OSC_ESC: begin
            if (in_byte != BYTE_BSLASH && in_byte != BYTE_BEL)
               mode_in = (in_byte == BYTE_ESC) ? MODE_OSC_ESC : MODE_OSC;
         end
         MODE_OSC: begin
            if (in_byte != BYTE_BEL)
               mode_in = (in_byte == BYTE_ESC) ? MODE_OSC_ESC : MODE_OSC;
         end
         MODE_CR_PEND: begin
            plan.pre_lf = 1'b1;
            if (in_byte != BYTE_LF) plain = 1'b1;
         end
         MODE_SKIP: begin
            if ((in_byte & CONT_MASK) == BYTE_HIGH) mode_in = MODE_SKIP;
            else plain = 1'b1;
         end
         default: plain = 1'b1;
      endcase

      if (plan.pre_lf) cnt1 = (count_ff == CNT_TOP) ? '0 : count_ff + 1'b1;
      else cnt1 = count_ff;

      sp   = STOP5 - 5'(cnt1);
      cap  = plan.pre_lf ? (MAX_RESULTS - 3'd1) : MAX_RESULTS;
      emit = (sp < 5'(cap)) ? sp[2:0] : cap;
      sum  = 5'(cnt1) + 5'(emit);

      count_in = cnt1;
      if (plain) begin
         if (in_byte == BYTE_ESC) begin
            mode_in = MODE_START;
         end else if (in_byte == BYTE_CR) begin
            if (in_last) begin
               plan.body_char = CHAR_LF;
               plan.body_cnt  = 3'd1;
            end else begin
               mode_in = MODE_CR_PEND;
            end
         end else if (in_byte == BYTE_TAB) begin
            plan.body_char = CHAR_SPACE;
            plan.body_cnt  = emit;
            count_in = (5'(emit) == sp) ? '0 : sum[CW-1:0];
         end else if (in_byte == BYTE_LF || (in_byte >= BYTE_SPACE && in_byte <= BYTE_TILDE)) begin
            plan.body_char = in_byte[6:0];
            plan.body_cnt  = 3'd1;
         end else if (in_byte >= BYTE_HIGH) begin
            plan.body_char = CHAR_QMARK;
            plan.body_cnt  = 3'd1;
            mode_in = MODE_SKIP;
         end
         if (in_byte != BYTE_TAB && plan.body_cnt != 3'd0)
            count_in = (cnt1 == CNT_TOP) ? '0 : cnt1 + 1'b1;
      end

      if (in_last) begin
         mode_in  = MODE_NORMAL;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         count_ff <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/terminal_text_sanitizer.sv -----
// Top level of the terminal text sanitizer: request register, parser and result sequencer.
// Flow: an accepted request is held in the request register, then its plan is loaded into the
// result sequencer, which presents the first result.
// Throughput: one request per cycle while rsp_stall is low and each request yields at most one
// result; more results (tab expansion, CR flush) hold the sequencer until the last is taken.
// Reset: synchronous; returns the parser to normal text mode, the output count to zero
// and empties the request register and the result sequencer.
module terminal_text_sanitizer #(
   parameter int TAB_STOP = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_run_last,
   output logic       rsp_text_end
);
   import tts_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic       gen_valid_ff;
   logic       pre_lf_ff;
   logic [6:0] body_ff;
   logic [2:0] cnt_ff;
   logic       last_ff;

   plan_type   plan;
   logic       one_left;
   logic       gen_free;
   logic       advance;
   logic       has_output;

   tts_parser #(.TAB_STOP(TAB_STOP)) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .plan    (plan)
   );

   assign one_left = pre_lf_ff ? (cnt_ff == 3'd0) : (cnt_ff <= 3'd1);
   assign gen_free = !gen_valid_ff || (!rsp_stall && one_left);
   assign advance  = in_valid_ff && gen_free;
   assign req_stall = in_valid_ff && !gen_free;
   assign has_output = plan.pre_lf || plan.body_cnt != 3'd0 || plan.text_last;

   assign rsp_valid      = gen_valid_ff;
   assign rsp_out_char   = pre_lf_ff ? CHAR_LF : body_ff;
   assign rsp_char_valid = pre_lf_ff || cnt_ff != 3'd0;
   assign rsp_run_last   = one_left;
   assign rsp_text_end   = one_left && last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_valid_ff <= 1'b0;
      end else if (gen_free) begin
         gen_valid_ff <= advance && has_output;
      end
      if (advance && gen_free) begin
         pre_lf_ff <= plan.pre_lf;
         body_ff   <= plan.body_char;
         cnt_ff    <= plan.body_cnt;
         last_ff   <= plan.text_last;
      end else if (gen_valid_ff && !rsp_stall && !one_left) begin
         if (pre_lf_ff) pre_lf_ff <= 1'b0;
         else cnt_ff <= cnt_ff - 3'd1;
      end
   end

endmodule
